// ===== hdl/frame_block_averager_unit_macros.svh =====
// Assertion macros shared by the frame block averager RTL.
`ifndef FRAME_BLOCK_AVERAGER_UNIT_MACROS_SVH
`define FRAME_BLOCK_AVERAGER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FBA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame_block_averager_unit: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame_block_averager_unit: next-cycle check failed");

`endif

// ===== hdl/fba_pkg.sv =====
// Package of the frame block averager: sizes, register codes and shared types.
package fba_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int MAX_FRAMES  = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int POS_BITS       = $clog2(MAX_SAMPLES);
  localparam int LEN_BITS       = POS_BITS + 1;
  localparam int FRAMES_BITS    = $clog2(MAX_FRAMES) + 1;
  localparam int SUM_BITS       = SAMPLE_BITS + $clog2(MAX_FRAMES);
  localparam int AZ_BITS        = 32;
  localparam int FN_BITS        = 32;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int DIV_STAGES     = SUM_BITS;

  // Register reset values and clamp limits
  localparam logic [FRAMES_BITS-1:0] FRAMES_RESET = FRAMES_BITS'(1024);
  localparam logic [LEN_BITS-1:0]    LEN_RESET    = LEN_BITS'(1024);
  localparam logic [FRAMES_BITS-1:0] FRAMES_MAX   = FRAMES_BITS'(MAX_FRAMES);
  localparam logic [LEN_BITS-1:0]    LEN_MAX      = LEN_BITS'(MAX_SAMPLES);

  // Saturation limits of the average
  localparam logic [SUM_BITS-1:0] SAT_POS_MAG = SUM_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic [SUM_BITS-1:0] SAT_NEG_MAG = SUM_BITS'(2 ** (SAMPLE_BITS - 1));
  localparam logic [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAMES_TO_AVERAGE = CFG_INDEX_BITS'(0),
    REG_SAMPLES_PER_FRAME = CFG_INDEX_BITS'(1)
  } cfg_reg_t;

  // Classified word handed from the front to the back
  typedef struct packed {
    logic [POS_BITS-1:0]           pos;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [AZ_BITS-1:0]            azimuth;
    logic                          first;
    logic                          last_frame;
    logic                          frame_end;
    logic [FN_BITS-1:0]            frame_number;
    logic [FRAMES_BITS-1:0]        n;
  } cmd_t;

  // Queue status
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  // Finished sum handed to the divider
  typedef struct packed {
    logic                   valid;
    logic                   neg;
    logic [SUM_BITS-1:0]    mag;
    logic [FRAMES_BITS-1:0] n;
    logic [AZ_BITS-1:0]     azimuth;
    logic [FN_BITS-1:0]     frame_number;
    logic                   last;
  } div_in_t;

endpackage

// ===== hdl/fba_front.sv =====
// Front of the averager: config registers, position and frame counters, classification.
module fba_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [fba_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [fba_pkg::AZ_BITS-1:0]         azimuth,
  input  logic                                cfg_valid,
  input  logic [fba_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [fba_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  fba_pkg::fifo_status_t               fifo_status,
  output logic                                push,
  output fba_pkg::cmd_t                       cmd
);
  import fba_pkg::*;

  logic [FRAMES_BITS-1:0] frames_to_average;
  logic [LEN_BITS-1:0]    samples_per_frame;
  logic [POS_BITS-1:0]    sample_position;
  logic [FRAMES_BITS-1:0] frames_collected;
  logic [FN_BITS-1:0]     output_frame_count;

  logic [FRAMES_BITS-1:0] n_eff;
  logic [LEN_BITS-1:0]    len_eff;
  logic                   last_frame;
  logic                   frame_end;

  // Out-of-range register values clamp to 1..max
  always_comb begin
    if (frames_to_average == '0) begin
      n_eff = FRAMES_BITS'(1);
    end else if (frames_to_average > FRAMES_MAX) begin
      n_eff = FRAMES_MAX;
    end else begin
      n_eff = frames_to_average;
    end
    if (samples_per_frame == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (samples_per_frame > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = samples_per_frame;
    end
  end

  // Classify the incoming word
  assign last_frame = ({1'b0, frames_collected} + 1'b1) >= {1'b0, n_eff};
  assign frame_end  = ({1'b0, sample_position} + 1'b1) >= len_eff;

  assign in_stall = fifo_status.full;
  assign push     = in_valid && !fifo_status.full;

  always_comb begin
    cmd.pos          = sample_position;
    cmd.sample       = sample;
    cmd.azimuth      = azimuth;
    cmd.first        = (frames_collected == '0);
    cmd.last_frame   = last_frame;
    cmd.frame_end    = frame_end;
    cmd.frame_number = output_frame_count;
    cmd.n            = n_eff;
  end

  // Config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_to_average <= FRAMES_RESET;
      samples_per_frame <= LEN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAMES_TO_AVERAGE: frames_to_average <= cfg_data[FRAMES_BITS-1:0];
        REG_SAMPLES_PER_FRAME: samples_per_frame <= cfg_data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Position, frame and output frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position    <= '0;
      frames_collected   <= '0;
      output_frame_count <= '0;
    end else if (push) begin
      if (frame_end) begin
        sample_position <= '0;
        if (last_frame) begin
          frames_collected   <= '0;
          output_frame_count <= output_frame_count + 1'b1;
        end else begin
          frames_collected <= frames_collected + 1'b1;
        end
      end else begin
        sample_position <= sample_position + 1'b1;
      end
    end
  end

endmodule

// ===== hdl/fba_fifo.sv =====
// Short queue of classified words between the front and the back.
module fba_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  fba_pkg::cmd_t         cmd_in,
  input  logic                  pop,
  output fba_pkg::cmd_t         head,
  output fba_pkg::fifo_status_t status
);
  import fba_pkg::*;

  cmd_t                   entries [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr;
  logic [FIFO_PTR_BITS-1:0] rd_ptr;
  logic [FIFO_PTR_BITS:0]   count;

  assign head         = entries[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == (FIFO_PTR_BITS + 1)'(FIFO_DEPTH));

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/fba_accum.sv =====
// Back part one: per-position sum memory with read-modify-write and forwarding.
module fba_accum (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  fba_pkg::cmd_t         head,
  input  fba_pkg::fifo_status_t fifo_status,
  output logic                  pop,
  output fba_pkg::div_in_t      div_in
);
  import fba_pkg::*;

  logic [SUM_BITS-1:0] sum_mem [MAX_SAMPLES];
  logic [SUM_BITS-1:0] rd_data;

  logic                s1_valid;
  cmd_t                s1_cmd;
  logic                s1_hit;
  logic [SUM_BITS-1:0] s1_prev;

  logic [SUM_BITS-1:0] sample_ext;
  logic [SUM_BITS-1:0] base;
  logic [SUM_BITS-1:0] sum_new;
  logic                neg;

  assign pop = adv && !fifo_status.empty;

  // Memory read of the head word's position, held while frozen
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= sum_mem[head.pos];
    end
  end

  // Write back of the updated sum
  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      sum_mem[s1_cmd.pos] <= sum_new;
    end
  end

  // Update: first frame overwrites, later frames add; forward a same-position write
  assign sample_ext = {{(SUM_BITS - SAMPLE_BITS){s1_cmd.sample[SAMPLE_BITS-1]}}, s1_cmd.sample};
  assign base       = s1_hit ? s1_prev : rd_data;
  assign sum_new    = s1_cmd.first ? sample_ext : (base + sample_ext);
  assign neg        = sum_new[SUM_BITS-1];

  always_comb begin
    div_in.valid        = s1_valid && s1_cmd.last_frame;
    div_in.neg          = neg;
    div_in.mag          = neg ? (SUM_BITS'(0) - sum_new) : sum_new;
    div_in.n            = s1_cmd.n;
    div_in.azimuth      = s1_cmd.azimuth;
    div_in.frame_number = s1_cmd.frame_number;
    div_in.last         = s1_cmd.frame_end;
  end

  // Stage register behind the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= !fifo_status.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd  <= head;
      s1_hit  <= s1_valid && (s1_cmd.pos == head.pos);
      s1_prev <= sum_new;
    end
  end

endmodule

// ===== hdl/fba_div.sv =====
// Back part two: pipelined restoring divider, sign and saturation, output register.
module fba_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fba_pkg::div_in_t                       div_in,
  output logic                                   adv,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [fba_pkg::SAMPLE_BITS-1:0] average,
  output logic [fba_pkg::AZ_BITS-1:0]            out_azimuth,
  output logic [fba_pkg::FN_BITS-1:0]            frame_number,
  output logic                                   last_sample
);
  import fba_pkg::*;

  typedef struct packed {
    logic                   neg;
    logic [FRAMES_BITS-1:0] rem;
    logic [SUM_BITS-1:0]    quo;
    logic [FRAMES_BITS-1:0] n;
    logic [AZ_BITS-1:0]     azimuth;
    logic [FN_BITS-1:0]     frame_number;
    logic                   last;
  } div_word_t;

  div_word_t              stage       [DIV_STAGES + 1];
  logic                   stage_valid [DIV_STAGES + 1];
  div_word_t              step        [DIV_STAGES];
  logic [FRAMES_BITS:0]   trial       [DIV_STAGES];

  logic [SUM_BITS-1:0]    quo_final;
  logic [SUM_BITS-1:0]    quo_neg;
  logic [SAMPLE_BITS-1:0] avg_next;

  // Whole back part moves when the output register is free or being taken
  assign adv = !out_valid || !out_stall;

  // One quotient bit per stage: shift in a dividend bit, compare, subtract
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      trial[k] = {stage[k].rem, stage[k].quo[SUM_BITS-1]};
      step[k]  = stage[k];
      if (trial[k] >= {1'b0, stage[k].n}) begin
        step[k].rem = FRAMES_BITS'(trial[k] - {1'b0, stage[k].n});
        step[k].quo = {stage[k].quo[SUM_BITS-2:0], 1'b1};
      end else begin
        step[k].rem = trial[k][FRAMES_BITS-1:0];
        step[k].quo = {stage[k].quo[SUM_BITS-2:0], 1'b0};
      end
    end
  end

  // Restore the sign (toward zero) and saturate to the sample range
  assign quo_final = stage[DIV_STAGES].quo;
  assign quo_neg   = SUM_BITS'(0) - quo_final;

  always_comb begin
    if (stage[DIV_STAGES].neg) begin
      avg_next = (quo_final > SAT_NEG_MAG) ? SAT_LO : quo_neg[SAMPLE_BITS-1:0];
    end else begin
      avg_next = (quo_final > SAT_POS_MAG) ? SAT_HI : quo_final[SAMPLE_BITS-1:0];
    end
  end

  // Stage valid bits and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        stage_valid[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      stage_valid[0] <= div_in.valid;
      for (int k = 0; k < DIV_STAGES; k++) begin
        stage_valid[k + 1] <= stage_valid[k];
      end
      out_valid <= stage_valid[DIV_STAGES];
    end
  end

  // Stage payloads and output word
  always_ff @(posedge clk) begin
    if (adv) begin
      stage[0].neg          <= div_in.neg;
      stage[0].rem          <= '0;
      stage[0].quo          <= div_in.mag;
      stage[0].n            <= div_in.n;
      stage[0].azimuth      <= div_in.azimuth;
      stage[0].frame_number <= div_in.frame_number;
      stage[0].last         <= div_in.last;
      for (int k = 0; k < DIV_STAGES; k++) begin
        stage[k + 1] <= step[k];
      end
      average      <= avg_next;
      out_azimuth  <= stage[DIV_STAGES].azimuth;
      frame_number <= stage[DIV_STAGES].frame_number;
      last_sample  <= stage[DIV_STAGES].last;
    end
  end

endmodule

// ===== hdl/frame_block_averager_unit.sv =====
// Top level of the frame block averager: front, word queue, sum memory, divider.
// Throughput: one sample word per cycle; a stalled output freezes the back part.
// Path: an accepted word passes the queue, the sum memory read-modify-write stage, the
// divider's 26 stages and the output register before its average leaves.
// Reset: counters, queue and valid bits clear, registers go to 1024 frames and 1024 samples;
// the sum memory is not cleared, the first frame of every group overwrites it.
`include "frame_block_averager_unit_macros.svh"

module frame_block_averager_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [fba_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [fba_pkg::AZ_BITS-1:0]            azimuth,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [fba_pkg::SAMPLE_BITS-1:0] average,
  output logic [fba_pkg::AZ_BITS-1:0]            out_azimuth,
  output logic [fba_pkg::FN_BITS-1:0]            frame_number,
  output logic                                   last_sample,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [fba_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [fba_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import fba_pkg::*;

  logic         push;
  cmd_t         cmd;
  cmd_t         head;
  fifo_status_t fifo_status;
  logic         pop;
  logic         adv;
  div_in_t      div_in;

  // Registers take a write in any cycle
  assign cfg_ready = 1'b1;

  fba_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .azimuth     (azimuth),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fifo_status (fifo_status),
    .push        (push),
    .cmd         (cmd)
  );

  fba_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .cmd_in (cmd),
    .pop    (pop),
    .head   (head),
    .status (fifo_status)
  );

  fba_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .head        (head),
    .fifo_status (fifo_status),
    .pop         (pop),
    .div_in      (div_in)
  );

  fba_div u_div (
    .clk          (clk),
    .rst          (rst),
    .div_in       (div_in),
    .adv          (adv),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .average      (average),
    .out_azimuth  (out_azimuth),
    .frame_number (frame_number),
    .last_sample  (last_sample)
  );

  // A word leaves the queue only when there is one and the back part moves
  `FBA_ASSERT_IMPLY(a_pop_has_word, clk, rst, pop, (!fifo_status.empty && adv))

  // Results inside one output frame share its frame number
  `FBA_ASSERT_NEXT(a_fn_same_in_frame, clk, rst, (out_valid && !out_stall && !last_sample),
                   (!out_valid || frame_number == $past(frame_number)))

  // The result after a frame's last sample belongs to the next output frame
  `FBA_ASSERT_NEXT(a_fn_steps_after_last, clk, rst, (out_valid && !out_stall && last_sample),
                   (!out_valid || frame_number == $past(frame_number) + 1'b1))

endmodule

// ===== tb/sv/frame_block_averager_unit_checker.sv =====
`timescale 1ns / 1ps
// Checker of the frame block averager: running-sum predictor and result scoreboard.
module frame_block_averager_unit_checker
  import fba_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [AZ_BITS-1:0]            azimuth,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] average,
  input  logic [AZ_BITS-1:0]            out_azimuth,
  input  logic [FN_BITS-1:0]            frame_number,
  input  logic                          last_sample,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  output int                            mismatch_count,
  output int                            averages_due
);

  // One averaged output word
  typedef struct {
    logic signed [SAMPLE_BITS-1:0] average;
    logic [AZ_BITS-1:0]            azimuth;
    logic [FN_BITS-1:0]            frame_number;
    logic                          last;
  } avg_word_t;

  avg_word_t               due_q[$];
  longint                  position_total[MAX_SAMPLES];
  logic [POS_BITS-1:0]     at_pos;
  logic [FRAMES_BITS-1:0]  frames_in_group;
  logic [FN_BITS-1:0]      frames_out;
  logic [FRAMES_BITS-1:0]  group_size_reg;
  logic [LEN_BITS-1:0]     frame_len_reg;
  int                      errors_seen;

  // Out-of-range register values act as the nearest legal one
  function automatic int effective(int raw, int hi);
    if (raw < 1) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // Fold one sample into its position sum; emit the average on a group's last frame
  task automatic fold_sample(input logic signed [SAMPLE_BITS-1:0] s,
                             input logic [AZ_BITS-1:0] az);
    int        n;
    int        len;
    bit        last_frame;
    bit        frame_end;
    longint    mean;
    avg_word_t w;
    n          = effective(int'(group_size_reg), MAX_FRAMES);
    len        = effective(int'(frame_len_reg), MAX_SAMPLES);
    last_frame = int'(frames_in_group) + 1 >= n;
    frame_end  = int'(at_pos) + 1 >= len;
    if (frames_in_group == '0)
      position_total[at_pos] = s;
    else
      position_total[at_pos] = position_total[at_pos] + s;
    if (last_frame) begin
      mean = position_total[at_pos] / n;
      if (mean > longint'($signed(SAT_HI))) mean = longint'($signed(SAT_HI));
      if (mean < longint'($signed(SAT_LO))) mean = longint'($signed(SAT_LO));
      w.average      = SAMPLE_BITS'(mean);
      w.azimuth      = az;
      w.frame_number = frames_out;
      w.last         = frame_end;
      due_q.push_back(w);
    end
    if (frame_end) begin
      at_pos = '0;
      if (last_frame) begin
        frames_in_group = '0;
        frames_out      = frames_out + 1'b1;
      end else begin
        frames_in_group = frames_in_group + 1'b1;
      end
    end else begin
      at_pos = at_pos + 1'b1;
    end
  endtask

  // Compare one accepted output word with the oldest expectation
  task automatic check_average();
    avg_word_t want;
    if (due_q.size() == 0) begin
      $error("unexpected average word: average %0d, out_azimuth %0h, frame_number %0d",
             average, out_azimuth, frame_number);
      errors_seen++;
    end else begin
      want = due_q.pop_front();
      if (average !== want.average) begin
        $error("average: expected %0d, got %0d", want.average, average);
        errors_seen++;
      end
      if (out_azimuth !== want.azimuth) begin
        $error("out_azimuth: expected %0h, got %0h", want.azimuth, out_azimuth);
        errors_seen++;
      end
      if (frame_number !== want.frame_number) begin
        $error("frame_number: expected %0d, got %0d", want.frame_number, frame_number);
        errors_seen++;
      end
      if (last_sample !== want.last) begin
        $error("last_sample: expected %0b, got %0b", want.last, last_sample);
        errors_seen++;
      end
    end
  endtask

  // Watch all three channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      at_pos          = '0;
      frames_in_group = '0;
      frames_out      = '0;
      group_size_reg  = FRAMES_RESET;
      frame_len_reg   = LEN_RESET;
      due_q.delete();
    end else begin
      if (out_valid && !out_stall) check_average();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAMES_TO_AVERAGE: group_size_reg = cfg_data[FRAMES_BITS-1:0];
          REG_SAMPLES_PER_FRAME: frame_len_reg  = cfg_data[LEN_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) fold_sample(sample, azimuth);
    end
    mismatch_count <= errors_seen;
    averages_due   <= due_q.size();
  end

endmodule

// ===== tb/sv/frame_block_averager_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top of the frame block averager: clock, reset, stimulus and verdict.
module frame_block_averager_unit_tb;
  import fba_pkg::*;

  localparam int RANDOM_WORDS   = 1550;
  localparam int SETTLE_CYCLES  = 40;
  localparam int IDLE_LIMIT     = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_WORD   = 500;
  localparam int PRESSURE_WORDS = 120;
  localparam int STEADY_FIRST   = 800;
  localparam int STEADY_LAST    = 1100;
  localparam int RX_QUIET_FROM  = 4000;
  localparam int RX_QUIET_TO    = 6500;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [AZ_BITS-1:0]            azimuth;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] average;
  logic [AZ_BITS-1:0]            out_azimuth;
  logic [FN_BITS-1:0]            frame_number;
  logic                          last_sample;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_INDEX_BITS-1:0]     cfg_index;
  logic [CFG_DATA_BITS-1:0]      cfg_data;
  int                            mismatch_count;
  int                            averages_due;

  // Stimulus-side view of frame progress, used to pick safe register values
  int  mirror_frames = MAX_FRAMES;
  int  mirror_len    = MAX_SAMPLES / 4;
  int  mirror_pos    = 0;
  int  mirror_done   = 0;
  bit  pos_written[MAX_SAMPLES];
  int  words_sent    = 0;
  bit  steady_tx     = 1'b0;
  bit  hold_request  = 1'b0;
  int  idle_run      = 0;

  frame_block_averager_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .azimuth      (azimuth),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .average      (average),
    .out_azimuth  (out_azimuth),
    .frame_number (frame_number),
    .last_sample  (last_sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  frame_block_averager_unit_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .azimuth        (azimuth),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .average        (average),
    .out_azimuth    (out_azimuth),
    .frame_number   (frame_number),
    .last_sample    (last_sample),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .averages_due   (averages_due)
  );

  // 100 MHz clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: cycles in a row with no word moving on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= IDLE_LIMIT) begin
      $display("frame_block_averager_unit verification failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Receiver: random stalls, a quiet window, and one long hold-off
  initial begin : receiver
    int rx_cycle;
    int hold_left;
    bit hold_done;
    rx_cycle  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_cycle >= RX_QUIET_FROM && rx_cycle < RX_QUIET_TO) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 10);
      end
    end
  end

  function automatic int clamp_setting(int raw, int hi);
    if (raw < 1) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // Register write; only called with the block drained
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAMES_TO_AVERAGE)
      mirror_frames = clamp_setting(int'(data[FRAMES_BITS-1:0]), MAX_FRAMES);
    else if (idx == REG_SAMPLES_PER_FRAME)
      mirror_len = clamp_setting(int'(data[LEN_BITS-1:0]), MAX_SAMPLES);
  endtask

  // Offer one sample word, with random gaps, and track frame progress
  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s,
                             input logic [AZ_BITS-1:0] az);
    @(negedge clk);
    while (!steady_tx && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    azimuth  <= az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pos_written[mirror_pos] = 1'b1;
    if (mirror_pos + 1 >= mirror_len) begin
      mirror_pos  = 0;
      mirror_done = (mirror_done + 1 >= mirror_frames) ? 0 : mirror_done + 1;
    end else begin
      mirror_pos++;
    end
    words_sent++;
  endtask

  // Drain: every average in, then let the pipeline run dry
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (averages_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 5) return SAT_HI;
    if (r < 10) return SAT_LO;
    return SAMPLE_BITS'($urandom);
  endfunction

  // Frame count: mostly small, now and then zero, the maximum or beyond it
  function automatic logic [CFG_DATA_BITS-1:0] pick_frames();
    logic [CFG_DATA_BITS-1:0] data;
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 60) n = $urandom_range(4, 1);
    else if (r < 85) n = $urandom_range(16, 5);
    else if (r < 95) n = $urandom_range(64, 17);
    else begin
      case ($urandom_range(2))
        0: n = 0;
        1: n = MAX_FRAMES;
        default: n = $urandom_range((1 << FRAMES_BITS) - 1, MAX_FRAMES + 1);
      endcase
    end
    data = CFG_DATA_BITS'($urandom);
    data[FRAMES_BITS-1:0] = FRAMES_BITS'(n);
    return data;
  endfunction

  // Frame length; mid-group it never reaches a position not yet written
  function automatic logic [CFG_DATA_BITS-1:0] pick_length();
    logic [CFG_DATA_BITS-1:0] data;
    int r;
    int len;
    int prefix;
    r = $urandom_range(99);
    if (r < 60) len = $urandom_range(8, 1);
    else if (r < 90) len = $urandom_range(32, 9);
    else if (r < 95) len = $urandom_range(200, 33);
    else begin
      case ($urandom_range(2))
        0: len = 0;
        1: len = MAX_SAMPLES;
        default: len = $urandom_range((1 << LEN_BITS) - 1, MAX_SAMPLES + 1);
      endcase
    end
    if (mirror_done != 0) begin
      prefix = 0;
      while (prefix < MAX_SAMPLES && pos_written[prefix]) prefix++;
      if (clamp_setting(len, MAX_SAMPLES) > prefix) len = prefix;
    end
    data = CFG_DATA_BITS'($urandom);
    data[LEN_BITS-1:0] = LEN_BITS'(len);
    return data;
  endfunction

  // Stimulus
  initial begin : stimulus
    int                 r;
    int                 rem_frames;
    int                 to_end;
    int                 burst;
    int                 target;
    logic [AZ_BITS-1:0] frame_az;
    rst       = 1'b1;
    in_valid  = 1'b0;
    sample    = '0;
    azimuth   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Field extremes, one frame per frame group
    write_reg(REG_FRAMES_TO_AVERAGE, 16'h0001);
    write_reg(REG_SAMPLES_PER_FRAME, 16'h0004);
    push_sample(SAT_HI, 32'h0000_0000);
    push_sample(SAT_LO, 32'hFFFF_FFFF);
    push_sample(16'sd0, 32'hAAAA_AAAA);
    push_sample(-16'sd1, 32'h5555_5555);

    // Two-frame average, truncation toward zero; upper data bits ignored
    settle();
    write_reg(REG_FRAMES_TO_AVERAGE, 16'hF802);
    write_reg(REG_SAMPLES_PER_FRAME, 16'hE002);
    push_sample(SAT_HI, 32'h0000_0001);
    push_sample(-16'sd3, 32'h0000_0001);
    push_sample(16'sd32766, 32'h0000_0002);
    push_sample(16'sd0, 32'h0000_0002);

    // Zero frame count and zero length both act as one
    settle();
    write_reg(REG_FRAMES_TO_AVERAGE, 16'hF800);
    write_reg(REG_SAMPLES_PER_FRAME, 16'hE000);
    push_sample(SAT_LO, 32'h0000_0003);
    push_sample(SAT_HI, 32'h0000_0004);

    // Count above the maximum, then lowered mid-group: positive saturation
    settle();
    write_reg(REG_FRAMES_TO_AVERAGE, 16'h07FF);
    write_reg(REG_SAMPLES_PER_FRAME, 16'h0001);
    repeat (3) push_sample(SAT_HI, 32'h0000_0005);
    settle();
    write_reg(REG_FRAMES_TO_AVERAGE, 16'h0002);
    push_sample(SAT_HI, 32'h0000_0006);

    // Same with negative saturation
    settle();
    write_reg(REG_FRAMES_TO_AVERAGE, 16'h07FF);
    repeat (3) push_sample(SAT_LO, 32'h0000_0007);
    settle();
    write_reg(REG_FRAMES_TO_AVERAGE, 16'h0001);
    push_sample(SAT_LO, 32'h0000_0008);

    // Length above the maximum, then lowered below the current position
    settle();
    write_reg(REG_SAMPLES_PER_FRAME, 16'h1FFF);
    push_sample(16'sd100, 32'h0000_0009);
    push_sample(-16'sd100, 32'h0000_0009);
    push_sample(16'sd7, 32'h0000_0009);
    settle();
    write_reg(REG_SAMPLES_PER_FRAME, 16'h0002);
    push_sample(-16'sd7, 32'h0000_0009);

    // Length raised mid-group over positions already written
    settle();
    write_reg(REG_FRAMES_TO_AVERAGE, 16'h0002);
    write_reg(REG_SAMPLES_PER_FRAME, 16'h0002);
    push_sample(16'sd1000, 32'h0000_000A);
    push_sample(-16'sd1000, 32'h0000_000A);
    settle();
    write_reg(REG_SAMPLES_PER_FRAME, 16'h0004);
    repeat (4) push_sample(pick_sample(), 32'h0000_000B);

    // Random groups, some cut short by register changes
    target   = words_sent + RANDOM_WORDS;
    frame_az = $urandom;
    while (words_sent < target) begin
      settle();
      r = $urandom_range(99);
      if (r < 3)
        write_reg(CFG_INDEX_BITS'($urandom_range((1 << CFG_INDEX_BITS) - 1,
                                                 int'(REG_SAMPLES_PER_FRAME) + 1)),
                  CFG_DATA_BITS'($urandom));
      if (r % 4 != 1) write_reg(REG_FRAMES_TO_AVERAGE, pick_frames());
      if (r % 4 != 0) write_reg(REG_SAMPLES_PER_FRAME, pick_length());

      rem_frames = mirror_frames - mirror_done - 1;
      if (rem_frames < 0) rem_frames = 0;
      to_end = rem_frames * mirror_len + ((mirror_len > mirror_pos) ? mirror_len - mirror_pos : 1);
      if (to_end <= 150 && $urandom_range(99) < 85) begin
        burst = to_end + mirror_frames * mirror_len * $urandom_range(2);
        if (burst > 300) burst = to_end;
      end else begin
        burst = $urandom_range((to_end < 120) ? to_end : 120, 1);
      end

      // One long receiver hold-off: every word gives a result, so the block fills
      if (!hold_request && words_sent >= target - RANDOM_WORDS + HOLD_AT_WORD) begin
        write_reg(REG_FRAMES_TO_AVERAGE, 16'h0001);
        hold_request = 1'b1;
        burst        = PRESSURE_WORDS;
      end

      repeat (burst) begin
        steady_tx = (words_sent >= target - RANDOM_WORDS + STEADY_FIRST) &&
                    (words_sent < target - RANDOM_WORDS + STEADY_LAST);
        if (mirror_pos == 0) frame_az = $urandom;
        // now and then a stray azimuth inside a frame
        push_sample(pick_sample(), ($urandom_range(99) < 5) ? AZ_BITS'($urandom) : frame_az);
      end
    end

    // Drain and report
    settle();
    if (mismatch_count == 0 && averages_due == 0) begin
      $display("frame_block_averager_unit verification clean");
    end else begin
      $display("frame_block_averager_unit verification failed");
    end
    $finish;
  end

endmodule
